@@ hdl/gcs_pkg.sv @@
// Shared types and constants for the gray contrast stretch block.
package gcs_pkg;

  localparam logic [7:0] PixMax = 8'd255;
  localparam logic [7:0] PixMin = 8'd0;

  typedef enum logic {
    KIND_MEASURE = 1'b0,
    KIND_MAP     = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
  } range_t;

  typedef struct packed {
    logic        bypass;
    logic [7:0]  value;
    logic [15:0] num;
    logic [7:0]  den;
  } div_req_t;

endpackage

@@ hdl/gcs_range.sv @@
// Running minimum / maximum tracker for measure pixels.
module gcs_range (
  input  logic           clk,
  input  logic           rst,
  input  logic           upd,
  input  logic           restart,
  input  logic [7:0]     pixel,
  output gcs_pkg::range_t range
);

  logic [7:0] lo;
  logic [7:0] hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= gcs_pkg::PixMax;
      hi <= gcs_pkg::PixMin;
    end else if (upd) begin
      if (restart) begin
        lo <= pixel;
        hi <= pixel;
      end else begin
        if (pixel < lo) lo <= pixel;
        if (pixel > hi) hi <= pixel;
      end
    end
  end

  assign range.lo = lo;
  assign range.hi = hi;

endmodule

@@ hdl/gcs_div.sv @@
// Bit-serial restoring divider with round-half-to-even and a bypass path.
module gcs_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  gcs_pkg::div_req_t req,
  input  logic              take,
  output logic              idle,
  output logic              done,
  output logic [7:0]        result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_ROUND,
    S_DONE
  } state_t;

  state_t     state;
  logic [2:0] cnt;
  logic [7:0] rem;
  logic [7:0] sh;
  logic [7:0] den;
  logic [7:0] res;

  logic [8:0] trial;
  logic       qbit;
  logic [8:0] twor;
  logic       inc;

  assign trial = {rem, sh[7]};
  assign qbit  = (trial >= {1'b0, den});
  assign twor  = {rem, 1'b0};
  assign inc   = (twor > {1'b0, den}) || ((twor == {1'b0, den}) && sh[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (req.bypass) begin
              res   <= req.value;
              state <= S_DONE;
            end else begin
              rem   <= req.num[15:8];
              sh    <= req.num[7:0];
              den   <= req.den;
              cnt   <= '0;
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          rem <= qbit ? 8'(trial - {1'b0, den}) : trial[7:0];
          sh  <= {sh[6:0], qbit};
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) state <= S_ROUND;
        end
        S_ROUND: begin
          res   <= sh + {7'd0, inc};
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle   = (state == S_IDLE);
  assign done   = (state == S_DONE);
  assign result = res;

endmodule

@@ hdl/gray_contrast_stretch.sv @@
// Top level: min/max measurement and linear contrast stretch of 8-bit gray pixels.
// Measure transfer: range updated at the accepting edge, no result.
// Map transfer: the divider loads, runs 8 bit-serial steps, rounds, then waits in S_DONE
//   until the output register takes the result; input ready is low until it is idle.
// Map pixels outside the range or with an empty range bypass the divider into S_DONE.
// Synchronous active-high reset: range to min 255 / max 0, divider idle, output empty.
module gray_contrast_stretch (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pixel_in
  input  logic [1:0] s_axis_tuser,   // [0] kind, [1] frame_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] pixel_out
);

  gcs_pkg::range_t   range;
  gcs_pkg::div_req_t req;

  logic       acc;
  logic       is_map;
  logic       div_idle;
  logic       div_done;
  logic [7:0] div_res;
  logic       take;
  logic [7:0] diff;
  logic [7:0] pix;

  assign pix    = s_axis_tdata;
  assign acc    = s_axis_tvalid && s_axis_tready;
  assign is_map = (s_axis_tuser[0] == gcs_pkg::KIND_MAP);
  assign s_axis_tready = div_idle;

  gcs_range u_range (
    .clk     (clk),
    .rst     (rst),
    .upd     (acc && !is_map),
    .restart (s_axis_tuser[1]),
    .pixel   (pix),
    .range   (range)
  );

  assign diff = pix - range.lo;

  always_comb begin
    req.num = {diff, 8'd0} - {8'd0, diff};
    req.den = range.hi - range.lo;
    priority if (range.hi <= range.lo) begin
      req.bypass = 1'b1;
      req.value  = gcs_pkg::PixMin;
    end else if (pix <= range.lo) begin
      req.bypass = 1'b1;
      req.value  = gcs_pkg::PixMin;
    end else if (pix >= range.hi) begin
      req.bypass = 1'b1;
      req.value  = gcs_pkg::PixMax;
    end else begin
      req.bypass = 1'b0;
      req.value  = gcs_pkg::PixMin;
    end
  end

  assign take = !m_axis_tvalid || m_axis_tready;

  gcs_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (acc && is_map),
    .req    (req),
    .take   (take),
    .idle   (div_idle),
    .done   (div_done),
    .result (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= div_done;
      if (div_done) m_axis_tdata <= div_res;
    end
  end

endmodule

@@ hdl/gcs_checker.sv @@
// Port-level checker for gray_contrast_stretch and its bind.
module gcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_map_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) |=> !s_axis_tready)
    else $error("ready high right after map transfer");

  a_measure_free: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0]) |=> s_axis_tready)
    else $error("measure transfer blocked input");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output changed");

endmodule

bind gray_contrast_stretch gcs_checker u_gcs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ sim/tb.sv @@
// Self-checking testbench for gray_contrast_stretch: queued stream driver, predictor, monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 2000;
  localparam int RandItems = 1350;

  typedef struct {
    gcs_pkg::kind_t kind;
    logic [7:0]     pix;
    logic           start;
    bit             drain;
  } pix_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] pixel_in
  logic [1:0] s_axis_tuser = '0;   // [0] kind, [1] frame_start
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] pixel_out

  pix_item_t  pending[$];
  logic [7:0] want_pix[$];
  pix_item_t  nxt;
  logic [7:0] range_lo, range_hi;
  logic [7:0] got_pix;
  int         n_sent, n_err, idle_cycles;
  bit         calm;

  gray_contrast_stretch i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk = ~clk;

  assign calm = (n_sent >= 500) && (n_sent < 700);

  function automatic logic [7:0] stretch_pix(logic [7:0] p, logic [7:0] lo, logic [7:0] hi);
    int unsigned span, prod, q, rem;
    if (hi <= lo) return gcs_pkg::PixMin;
    if (p <= lo) return gcs_pkg::PixMin;
    if (p >= hi) return gcs_pkg::PixMax;
    span = hi - lo;
    prod = (p - lo) * 255;
    q    = prod / span;
    rem  = prod % span;
    if ((2 * rem > span) || ((2 * rem == span) && q[0])) q++;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  task automatic track_transfer(logic [1:0] user, logic [7:0] pix);
    if (gcs_pkg::kind_t'(user[0]) == gcs_pkg::KIND_MEASURE) begin
      if (user[1]) begin
        range_lo = pix;
        range_hi = pix;
      end else begin
        if (pix < range_lo) range_lo = pix;
        if (pix > range_hi) range_hi = pix;
      end
    end else begin
      want_pix.push_back(stretch_pix(pix, range_lo, range_hi));
    end
  endtask

  task automatic add_item(gcs_pkg::kind_t k, logic [7:0] p, logic st, bit dr = 1'b0);
    pix_item_t it;
    it.kind  = k;
    it.pix   = p;
    it.start = st;
    it.drain = dr;
    pending.push_back(it);
  endtask

  task automatic add_frame(bit dr);
    int lo, hi, nm, nmap;
    lo = $urandom_range(255);
    case ($urandom_range(3))
      0: hi = lo;
      1: hi = lo + $urandom_range(8);
      default: hi = lo + $urandom_range(255 - lo);
    endcase
    if (hi > 255) hi = 255;
    add_item(gcs_pkg::KIND_MEASURE, lo[7:0], 1'b1, dr);
    nm = $urandom_range(5);
    for (int i = 0; i < nm; i++)
      add_item(gcs_pkg::KIND_MEASURE, 8'($urandom_range(hi, lo)), 1'b0);
    add_item(gcs_pkg::KIND_MEASURE, hi[7:0], 1'b0);
    nmap = 1 + $urandom_range(11);
    for (int i = 0; i < nmap; i++) begin
      if ($urandom_range(9) < 7)
        add_item(gcs_pkg::KIND_MAP, 8'($urandom_range(hi, lo)), 1'($urandom_range(1)));
      else
        add_item(gcs_pkg::KIND_MAP, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // stream driver; predictor runs on each accepted input transfer
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_transfer(s_axis_tuser, s_axis_tdata);
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending.size() != 0 && !(pending[0].drain && want_pix.size() != 0) &&
            (calm || $urandom_range(99) >= 28)) begin
          nxt = pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.pix;
          s_axis_tuser  <= {nxt.start, nxt.kind};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_pix.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result: pixel_out %0d", m_axis_tdata);
        end else begin
          got_pix = want_pix.pop_front();
          if (m_axis_tdata !== got_pix) begin
            n_err++;
            if (n_err <= 10)
              $display("pixel_out mismatch: expected %0d, actual %0d", got_pix, m_axis_tdata);
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 28);
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    n_sent = 0;
    n_err = 0;
    idle_cycles = 0;
    range_lo = gcs_pkg::PixMax;
    range_hi = gcs_pkg::PixMin;

    // empty range after reset, frame_start ignored on map
    add_item(gcs_pkg::KIND_MAP, 8'd0, 1'b1);
    add_item(gcs_pkg::KIND_MAP, 8'd255, 1'b0);
    // flat range
    add_item(gcs_pkg::KIND_MEASURE, 8'd100, 1'b1);
    add_item(gcs_pkg::KIND_MAP, 8'd100, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd7, 1'b0);
    // below, at, above, inside range
    add_item(gcs_pkg::KIND_MEASURE, 8'd200, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd50, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd100, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd200, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd250, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd150, 1'b0);
    // exact halves: even quotient kept, odd rounded up
    add_item(gcs_pkg::KIND_MEASURE, 8'd0, 1'b1, 1'b1);
    add_item(gcs_pkg::KIND_MEASURE, 8'd6, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd1, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd3, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd5, 1'b1);
    // full range
    add_item(gcs_pkg::KIND_MEASURE, 8'd255, 1'b1);
    add_item(gcs_pkg::KIND_MEASURE, 8'd0, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd0, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd255, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd128, 1'b0);
    add_item(gcs_pkg::KIND_MAP, 8'd1, 1'b1);
    add_item(gcs_pkg::KIND_MAP, 8'd254, 1'b0);

    for (int f = 0; pending.size() < RandItems + 23; f++) begin
      if ($urandom_range(9) == 0) begin
        for (int i = 0; i < 1 + $urandom_range(4); i++)
          add_item(gcs_pkg::kind_t'(1'($urandom_range(1))), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      end else begin
        add_frame(f == 15 || f == 60);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (want_pix.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (n_err == 0 && want_pix.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (want_pix.size() != 0) $display("%0d results never arrived", want_pix.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/gcs_pkg.sv
hdl/gcs_range.sv
hdl/gcs_div.sv
hdl/gray_contrast_stretch.sv
hdl/gcs_checker.sv
sim/tb.sv
